// File: hw/rtl/fctc_pkg.sv
// ----------------------------------------------------------------------------
// fctc_pkg
// Types and constants shared by the four channel counter/timer modules.
// ----------------------------------------------------------------------------
package fctc_pkg;

  localparam int NUM_CH   = 4;
  localparam int CH_W     = 2;
  localparam int CPT_W    = 12;
  localparam int CNT_W    = 16;
  localparam int ACC_W    = 18;   // signed working count, holds count - 16*cpt

  localparam logic [CPT_W-1:0] CPT_RESET = 12'd364;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_RETI  = 2'd3;

  // control word bit positions
  localparam int CW_IRQ     = 7;
  localparam int CW_COUNTER = 6;
  localparam int CW_PRESCL  = 5;
  localparam int CW_PULSE   = 3;
  localparam int CW_TCONST  = 2;
  localparam int CW_RESET   = 1;
  localparam int CW_CTRL    = 0;

  localparam logic [7:0] CW_RESET_VAL = 8'h02;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] channel;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raise;
    logic [7:0] irq_vector;
    logic [3:0] pending_out;
    logic       in_service_out;
  } out_item_t;

  typedef struct packed {
    logic       raise;
    logic [7:0] vector;
  } poll_t;

endpackage

// File: hw/rtl/fctc_alu.sv
// ----------------------------------------------------------------------------
// fctc_alu
// Shared 18-bit signed add/subtract used for the tick decrement and the
// wrap reloads of every timer channel.
// ----------------------------------------------------------------------------
module fctc_alu (
  input  logic signed [fctc_pkg::ACC_W-1:0] a,
  input  logic signed [fctc_pkg::ACC_W-1:0] b,
  input  logic                              sub,
  output logic signed [fctc_pkg::ACC_W-1:0] res
);

  always_comb begin
    if (sub) begin
      res = a - b;
    end else begin
      res = a + b;
    end
  end

endmodule

// File: hw/rtl/fctc_poll.sv
// ----------------------------------------------------------------------------
// fctc_poll
// Interrupt daisy chain: picks the lowest pending channel when no interrupt
// is in service and builds its vector from the channel 0 vector byte.
// ----------------------------------------------------------------------------
module fctc_poll (
  input  logic [fctc_pkg::NUM_CH-1:0] pending,
  input  logic                        in_service,
  input  logic [7:0]                  vector_base,
  output fctc_pkg::poll_t             poll
);

  logic [fctc_pkg::CH_W-1:0] sel;

  always_comb begin
    sel = '0;
    priority if (pending[0]) begin
      sel = 2'd0;
    end else if (pending[1]) begin
      sel = 2'd1;
    end else if (pending[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    poll.raise  = !in_service && (pending != '0);
    // base low bits are masked off, so 2*channel just fills bits 2:1
    poll.vector = poll.raise ? {vector_base[7:3], sel, 1'b0} : 8'h00;
  end

endmodule

// File: hw/rtl/four_channel_counter_timer.sv
// ----------------------------------------------------------------------------
// four_channel_counter_timer
// Four channel counter/timer with a vectored, daisy-chained interrupt.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low. Exactly one result beat
// follows per item, shown for a single cycle with out_valid; it cannot be
// held off, so capture it when out_valid is high. A register write, a read or
// a return-from-interrupt goes from accept to the poll state and then to the
// result register. A tick walks the channels one at a time through a single
// shared 18-bit adder: stopped and counter-mode channels are skipped, and
// each running timer channel is decremented, then reloaded once per wrap
// this tick (at most 256). busy drops in the cycle the result is shown.
// clocks_per_tick is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module four_channel_counter_timer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  fctc_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output fctc_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fctc_pkg::CPT_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUB  = 4'b0010,
    ST_WRAP = 4'b0100,
    ST_POLL = 4'b1000
  } state_t;

  localparam int NC = fctc_pkg::NUM_CH;
  localparam int AW = fctc_pkg::ACC_W;

  state_t                         state_r, state_nxt;
  logic [15:0]                    count_r [NC];
  logic [15:0]                    count_nxt [NC];
  logic [7:0]                     tc_r [NC];
  logic [7:0]                     tc_nxt [NC];
  logic [7:0]                     cw_r [NC];
  logic [7:0]                     cw_nxt [NC];
  logic [7:0]                     vb_r [NC];
  logic [7:0]                     vb_nxt [NC];
  logic [NC-1:0]                  pend_r, pend_nxt;
  logic                           insvc_r, insvc_nxt;
  logic [fctc_pkg::CPT_W-1:0]     cpt_r;
  logic [fctc_pkg::CH_W-1:0]      ch_idx_r, ch_idx_nxt;
  logic signed [AW-1:0]           n_r, n_nxt;
  logic [7:0]                     rd_r, rd_nxt;
  logic                           out_valid_r, out_valid_nxt;
  fctc_pkg::out_item_t            out_item_r, out_item_nxt;

  logic [fctc_pkg::CH_W-1:0]      ch;
  logic [7:0]                     cw_cur;
  logic [7:0]                     tc_cur;
  logic [15:0]                    dec;
  logic signed [AW-1:0]           reload;
  logic signed [AW-1:0]           alu_a, alu_b, alu_res;
  logic                           alu_sub;
  logic                           skip;
  logic [7:0]                     hb3, hb3_new;
  fctc_pkg::poll_t                poll;

  assign ch     = (state_r == ST_IDLE) ? in_item.channel : ch_idx_r;
  assign cw_cur = cw_r[ch];
  assign tc_cur = tc_r[ch];
  assign skip   = (cw_cur[fctc_pkg::CW_TCONST] && cw_cur[fctc_pkg::CW_RESET])
               || cw_cur[fctc_pkg::CW_COUNTER];
  assign dec    = cw_cur[fctc_pkg::CW_PRESCL] ? {4'h0, cpt_r} : {cpt_r, 4'h0};
  assign reload = (tc_cur == 8'h00) ? AW'(32'h10000) : AW'({tc_cur, 8'h00});

  assign alu_sub = (state_r == ST_SUB);
  assign alu_a   = alu_sub ? AW'(count_r[ch]) : n_r;
  assign alu_b   = alu_sub ? AW'(dec) : reload;

  fctc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  fctc_poll u_poll (
    .pending     (pend_r),
    .in_service  (insvc_r),
    .vector_base (vb_r[0]),
    .poll        (poll)
  );

  assign hb3     = count_r[3][15:8];
  assign hb3_new = (hb3 != 8'h00) ? hb3 - 8'd1 : hb3;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tc_nxt        = tc_r;
    cw_nxt        = cw_r;
    vb_nxt        = vb_r;
    pend_nxt      = pend_r;
    insvc_nxt     = insvc_r;
    ch_idx_nxt    = ch_idx_r;
    n_nxt         = n_r;
    rd_nxt        = rd_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_nxt    = 8'h00;
          state_nxt = ST_POLL;
          unique case (in_item.kind)
            fctc_pkg::KIND_WRITE: begin
              if (cw_cur[fctc_pkg::CW_TCONST]) begin
                tc_nxt[ch] = in_item.write_data;
                if (cw_cur[fctc_pkg::CW_RESET]) begin
                  count_nxt[ch] = {in_item.write_data - 8'd1, 8'h00};
                end
                cw_nxt[ch][fctc_pkg::CW_TCONST] = 1'b0;
                cw_nxt[ch][fctc_pkg::CW_RESET]  = 1'b0;
              end else if (in_item.write_data[fctc_pkg::CW_CTRL]) begin
                cw_nxt[ch] = in_item.write_data;
                if (in_item.write_data[fctc_pkg::CW_RESET]
                    && !in_item.write_data[fctc_pkg::CW_TCONST]) begin
                  count_nxt[ch] = {tc_cur - 8'd1, 8'h00};
                end
                if (!in_item.write_data[fctc_pkg::CW_IRQ]) begin
                  pend_nxt[ch] = 1'b0;
                end
              end else begin
                vb_nxt[ch] = in_item.write_data;
              end
            end
            fctc_pkg::KIND_READ: begin
              rd_nxt = count_r[ch][15:8];
            end
            fctc_pkg::KIND_TICK: begin
              ch_idx_nxt = '0;
              state_nxt  = ST_SUB;
            end
            fctc_pkg::KIND_RETI: begin
              pend_nxt  = '0;
              insvc_nxt = 1'b0;
            end
            default: begin
              state_nxt = ST_POLL;
            end
          endcase
        end
      end

      ST_SUB: begin
        if (skip) begin
          ch_idx_nxt = ch_idx_r + 2'd1;
          if (ch_idx_r == 2'(NC - 1)) begin
            state_nxt = ST_POLL;
          end
        end else begin
          n_nxt     = alu_res;
          state_nxt = ST_WRAP;
        end
      end

      ST_WRAP: begin
        if (n_r < 0) begin
          // one wrap per cycle
          if (cw_cur[fctc_pkg::CW_IRQ]) begin
            pend_nxt[ch] = 1'b1;
          end
          if (ch_idx_r == 2'd2) begin
            if (cw_r[3][fctc_pkg::CW_COUNTER]) begin
              if (!(cw_r[3][fctc_pkg::CW_TCONST] && cw_r[3][fctc_pkg::CW_RESET])) begin
                if (hb3_new == 8'h00) begin
                  if (cw_r[3][fctc_pkg::CW_IRQ]) begin
                    pend_nxt[3] = 1'b1;
                  end
                  count_nxt[3] = {tc_r[3], 8'h00};
                end else begin
                  count_nxt[3] = {hb3_new, count_r[3][7:0]};
                end
              end
            end else begin
              cw_nxt[3][fctc_pkg::CW_PULSE] = 1'b0;
            end
          end
          n_nxt = alu_res;
        end else begin
          count_nxt[ch] = n_r[15:0];
          ch_idx_nxt    = ch_idx_r + 2'd1;
          state_nxt     = (ch_idx_r == 2'(NC - 1)) ? ST_POLL : ST_SUB;
        end
      end

      ST_POLL: begin
        if (poll.raise) begin
          insvc_nxt = 1'b1;
        end
        out_item_nxt.read_data      = rd_r;
        out_item_nxt.irq_raise      = poll.raise;
        out_item_nxt.irq_vector     = poll.vector;
        out_item_nxt.pending_out    = pend_r;
        out_item_nxt.in_service_out = insvc_r | poll.raise;
        out_valid_nxt               = 1'b1;
        state_nxt                   = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      insvc_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ch_idx_r    <= '0;
      cpt_r       <= fctc_pkg::CPT_RESET;
      for (int i = 0; i < NC; i++) begin
        count_r[i] <= '0;
        tc_r[i]    <= '0;
        cw_r[i]    <= fctc_pkg::CW_RESET_VAL;
        vb_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      insvc_r     <= insvc_nxt;
      out_valid_r <= out_valid_nxt;
      ch_idx_r    <= ch_idx_nxt;
      count_r     <= count_nxt;
      tc_r        <= tc_nxt;
      cw_r        <= cw_nxt;
      vb_r        <= vb_nxt;
      if (cfg_valid) begin
        cpt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    rd_r       <= rd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
